/* hdl/gda_pkg.sv */
// ============================================================================
// Gregorian date add/diff package
// Shared widths, payload structs, control structs and calendar tables.
// ============================================================================
`default_nettype none

package gda_pkg;

    // Field widths.
    localparam int YEAR_BITS     = 14;
    localparam int ADD_DAYS_BITS = 16;
    localparam int DAY_BITS      = 5;
    localparam int MONTH_BITS    = 4;
    localparam int DIFF_BITS     = 23;
    localparam int REM_BITS      = 7;

    // Calendar constants.
    localparam int DAYS_PER_YEAR = 365;
    localparam int CENTURY       = 100;
    localparam int NUM_MONTHS    = 12;
    localparam int FEBRUARY      = 2;
    localparam int LAST_DAY      = 31;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    // Reciprocal of one hundred: (x * DIV100_MUL) >> DIV100_SHIFT equals x / 100
    // for every x below 2^20, which covers every supported year width.
    localparam int DIV100_SHIFT    = 26;
    localparam int DIV100_MUL_BITS = 20;
    localparam logic [DIV100_MUL_BITS-1:0] DIV100_MUL = 20'd671089;

    // Request and result payloads.
    typedef struct packed {
        logic [DAY_BITS-1:0]      first_day;
        logic [MONTH_BITS-1:0]    first_month;
        logic [YEAR_BITS-1:0]     first_year;
        logic [DAY_BITS-1:0]      second_day;
        logic [MONTH_BITS-1:0]    second_month;
        logic [YEAR_BITS-1:0]     second_year;
        logic [ADD_DAYS_BITS-1:0] add_days;
    } req_t;

    typedef struct packed {
        logic [DAY_BITS-1:0]   sum_day;
        logic [MONTH_BITS-1:0] sum_month;
        logic [YEAR_BITS-1:0]  sum_year;
        logic                  year_overflow;
        logic [DIFF_BITS-1:0]  day_difference;
    } res_t;

    // Divide-by-100 unit control and status.
    typedef struct packed {
        logic                 start;
        logic [YEAR_BITS-1:0] dividend;
    } div_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [YEAR_BITS-1:0] quot;
        logic [REM_BITS-1:0]  rem;
    } div_res_t;

    // Running year tracker control and status.
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [YEAR_BITS-1:0] year;
        logic [REM_BITS-1:0]  r100;
        logic [1:0]           h4;
    } cal_ctl_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic                 leap_cur;
        logic                 leap_next;
        logic                 at_max;
    } cal_t;

    // Leap test from year mod 4, year mod 100 and (year / 100) mod 4.
    function automatic logic leap_of(input logic [1:0] lo2,
                                     input logic [REM_BITS-1:0] r100,
                                     input logic [1:0] h4);
        leap_of = ((lo2 == 2'd0) && (r100 != '0)) || ((r100 == '0) && (h4 == 2'd0));
    endfunction

    // Length of a month; months outside 1..12 read as 31 days.
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        case (m)
            4'd2:                      month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    // Days in the months before a month of a common year.
    function automatic logic [8:0] month_before(input logic [MONTH_BITS-1:0] m);
        case (m)
            4'd2:    month_before = 9'd31;
            4'd3:    month_before = 9'd59;
            4'd4:    month_before = 9'd90;
            4'd5:    month_before = 9'd120;
            4'd6:    month_before = 9'd151;
            4'd7:    month_before = 9'd181;
            4'd8:    month_before = 9'd212;
            4'd9:    month_before = 9'd243;
            4'd10:   month_before = 9'd273;
            4'd11:   month_before = 9'd304;
            4'd12:   month_before = 9'd334;
            default: month_before = 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hdl/gda_div100.sv */
// ============================================================================
// Divide by one hundred
// Reciprocal multiplication for the quotient, then a multiply-back and
// subtract for the remainder.
// ============================================================================
`default_nettype none

module gda_div100 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gda_pkg::div_ctl_t ctl,
    output gda_pkg::div_res_t      status
);
    import gda_pkg::*;

    localparam int PROD_W = YEAR_BITS + DIV100_MUL_BITS;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 phase_reg, phase_next;
    logic [YEAR_BITS-1:0] num_reg, num_next;
    logic [YEAR_BITS-1:0] quot_reg, quot_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]    prod;
    logic [YEAR_BITS-1:0] back;

    // Quotient from the scaled reciprocal of one hundred.
    assign prod = PROD_W'(num_reg) * PROD_W'(DIV100_MUL);
    // The whole hundreds, taken back out of the dividend for the remainder.
    assign back = quot_reg * YEAR_BITS'(CENTURY);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        phase_next = phase_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            phase_next = 1'b0;
            num_next   = ctl.dividend;
        end
        else if (busy_reg && !phase_reg)
        begin
            quot_next  = YEAR_BITS'(prod >> DIV100_SHIFT);
            phase_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = REM_BITS'(num_reg - back);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    // Dividend, quotient and remainder.
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign status.done = done_reg;
    assign status.quot = quot_reg;
    assign status.rem  = rem_reg;

    // A finished remainder always stays below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < REM_BITS'(CENTURY)))
        else $error("divider remainder out of range");

    // A finished division never overlaps a running one.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    // Each division ends right after its remainder step.
    a_done_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg && !ctl.start) |=> done_reg)
        else $error("divider did not finish");

endmodule

`default_nettype wire

/* hdl/gda_cal.sv */
// ============================================================================
// Running year tracker
// Holds the walking year with its mod-100 and century mod-4 counters, so the
// leap status of this year and the next is known without a division.
// ============================================================================
`default_nettype none

module gda_cal (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gda_pkg::cal_ctl_t ctl,
    output gda_pkg::cal_t          status
);
    import gda_pkg::*;

    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [REM_BITS-1:0]  r100_reg, r100_next;
    logic [1:0]           h4_reg, h4_next;
    logic [REM_BITS-1:0]  r100_inc;
    logic [1:0]           h4_inc;
    logic                 wrap;

    // Counters as they stand one year later.
    assign wrap     = (r100_reg == REM_BITS'(CENTURY - 1));
    assign r100_inc = wrap ? '0 : r100_reg + REM_BITS'(1);
    assign h4_inc   = wrap ? h4_reg + 2'd1 : h4_reg;

    always_comb
    begin
        year_next = year_reg;
        r100_next = r100_reg;
        h4_next   = h4_reg;
        if (ctl.load)
        begin
            year_next = ctl.year;
            r100_next = ctl.r100;
            h4_next   = ctl.h4;
        end
        else if (ctl.step)
        begin
            year_next = year_reg + YEAR_BITS'(1);
            r100_next = r100_inc;
            h4_next   = h4_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg <= year_next;
        r100_reg <= r100_next;
        h4_reg   <= h4_next;
    end

    assign status.year      = year_reg;
    assign status.leap_cur  = leap_of(year_reg[1:0], r100_reg, h4_reg);
    assign status.leap_next = leap_of(year_reg[1:0] + 2'd1, r100_inc, h4_inc);
    assign status.at_max    = (year_reg == YEAR_MAX);

    // The sequencer stops before stepping past the largest year.
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !ctl.load) |-> (year_reg != YEAR_MAX))
        else $error("year tracker stepped past the largest year");

    // A step moves the year forward by exactly one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !ctl.load) |=> (year_reg == $past(year_reg) + YEAR_BITS'(1)))
        else $error("year tracker step lost");

    // The mod-100 counter stays in range once loaded with a valid remainder.
    a_r100: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && (ctl.r100 < REM_BITS'(CENTURY))) |=> (r100_reg < REM_BITS'(CENTURY)))
        else $error("year tracker remainder out of range");

endmodule

`default_nettype wire

/* hdl/gregorian_date_add_and_diff.sv */
// ============================================================================
// Gregorian date add and day difference
// Clamps two dates, advances the first by a day count and gives the absolute
// day difference of the two dates.
// ============================================================================
// One request at a time. A request runs through fixed steps: the two year
// divisions by one hundred in the shared divider, the day clamps, the two
// serial day numbers and the difference, then a walk that skips whole years
// (about add_days/365, at most 179 with 16-bit day counts), a walk over the
// months that remain (at most 11), the result load and the return to idle.
// The result sits in an output register, so the next request can be taken
// while the previous result waits to be read; a result that finds that
// register still full waits in the final state until it drains.
`default_nettype none

module gregorian_date_add_and_diff (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire gda_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_stall,
    output gda_pkg::res_t      res
);
    import gda_pkg::*;

    localparam int SER_W  = YEAR_BITS + 10;
    localparam int ND_W   = ADD_DAYS_BITS + 1;
    localparam int SPAN_W = 9;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV1  = 4'd1;
    localparam logic [3:0] ST_DIV2  = 4'd2;
    localparam logic [3:0] ST_CLAMP = 4'd3;
    localparam logic [3:0] ST_SER1  = 4'd4;
    localparam logic [3:0] ST_SER2  = 4'd5;
    localparam logic [3:0] ST_DIFF  = 4'd6;
    localparam logic [3:0] ST_YEAR  = 4'd7;
    localparam logic [3:0] ST_MONTH = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]               state_reg, state_next;
    logic                     res_valid_reg, res_valid_next;
    res_t                     res_reg, res_next;

    logic [YEAR_BITS-1:0]     y1_reg, y1_next, y2_reg, y2_next;
    logic [MONTH_BITS-1:0]    m1_reg, m1_next, m2_reg, m2_next;
    logic [DAY_BITS-1:0]      d1_reg, d1_next, d2_reg, d2_next;
    logic [ADD_DAYS_BITS-1:0] add_reg, add_next;
    logic [YEAR_BITS-1:0]     q1_reg, q1_next, q2_reg, q2_next;
    logic [REM_BITS-1:0]      r1_reg, r1_next, r2_reg, r2_next;
    logic                     leap1_reg, leap1_next, leap2_reg, leap2_next;
    logic [SER_W-1:0]         s1_reg, s1_next, s2_reg, s2_next;
    logic [SER_W-1:0]         diff_reg, diff_next;
    logic [ND_W-1:0]          nd_reg, nd_next;
    logic [MONTH_BITS-1:0]    nm_reg, nm_next;
    logic                     ovf_reg, ovf_next;

    div_ctl_t                 div_ctl;
    div_res_t                 div_st;
    cal_ctl_t                 cal_ctl;
    cal_t                     cal_st;

    logic                     accept;
    logic                     res_load;
    logic [YEAR_BITS-1:0]     req_y1;

    logic                     leap1, leap2;
    logic [DAY_BITS-1:0]      lim1, lim2;

    logic                     ser_sel2;
    logic [YEAR_BITS-1:0]     ser_y, ser_q, ser_pc, ser_p4;
    logic [REM_BITS-1:0]      ser_r;
    logic [MONTH_BITS-1:0]    ser_m;
    logic [DAY_BITS-1:0]      ser_d;
    logic                     ser_leap;
    logic [SER_W-1:0]         ser_val;

    logic [SPAN_W-1:0]        span;
    logic [DAY_BITS-1:0]      dim;

    // Clamp helpers for the raw request fields.
    function automatic logic [MONTH_BITS-1:0] clamp_month(input logic [MONTH_BITS-1:0] m);
        if (m == '0)
            clamp_month = MONTH_BITS'(1);
        else if (m > MONTH_BITS'(NUM_MONTHS))
            clamp_month = MONTH_BITS'(NUM_MONTHS);
        else
            clamp_month = m;
    endfunction

    function automatic logic [YEAR_BITS-1:0] clamp_year(input logic [YEAR_BITS-1:0] y);
        clamp_year = (y == '0) ? YEAR_BITS'(1) : y;
    endfunction

    function automatic logic [DAY_BITS-1:0] clamp_day(input logic [DAY_BITS-1:0] d,
                                                      input logic [DAY_BITS-1:0] lim);
        if (d == '0)
            clamp_day = DAY_BITS'(1);
        else if (d > lim)
            clamp_day = lim;
        else
            clamp_day = d;
    endfunction

    // Shared divide-by-100 unit for both years.
    gda_div100 u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (div_ctl),
        .status (div_st)
    );

    // Walking year with its leap status.
    gda_cal u_cal (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cal_ctl),
        .status (cal_st)
    );

    // Handshake.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign res_load  = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);
    assign req_y1    = clamp_year(req.first_year);

    // Divider feeds: first year straight from the request, second from its register.
    assign div_ctl.start    = accept || ((state_reg == ST_DIV1) && div_st.done);
    assign div_ctl.dividend = (state_reg == ST_IDLE) ? req_y1 : y2_reg;

    // Leap status and month lengths of the clamped dates.
    assign leap1 = leap_of(y1_reg[1:0], r1_reg, q1_reg[1:0]);
    assign leap2 = leap_of(y2_reg[1:0], r2_reg, q2_reg[1:0]);
    assign lim1  = month_len(m1_reg, leap1);
    assign lim2  = month_len(m2_reg, leap2);

    // Serial day number, shared between the two dates.
    assign ser_sel2 = (state_reg == ST_SER2);
    assign ser_y    = ser_sel2 ? y2_reg : y1_reg;
    assign ser_q    = ser_sel2 ? q2_reg : q1_reg;
    assign ser_r    = ser_sel2 ? r2_reg : r1_reg;
    assign ser_m    = ser_sel2 ? m2_reg : m1_reg;
    assign ser_d    = ser_sel2 ? d2_reg : d1_reg;
    assign ser_leap = ser_sel2 ? leap2_reg : leap1_reg;
    // Quotient of (year - 1) by 100, and (year - 1) / 4.
    assign ser_pc   = (ser_r == '0) ? ser_q - YEAR_BITS'(1) : ser_q;
    assign ser_p4   = (ser_y - YEAR_BITS'(1)) >> 2;
    assign ser_val  = SER_W'(ser_y) * SER_W'(DAYS_PER_YEAR)
                    + SER_W'(ser_p4) - SER_W'(ser_pc) + SER_W'(ser_pc >> 2)
                    + SER_W'(month_before(ser_m))
                    + SER_W'(ser_leap && (ser_m > MONTH_BITS'(FEBRUARY)))
                    + SER_W'(ser_d);

    // Twelve months from the current month span 365 or 366 days.
    assign span = SPAN_W'(DAYS_PER_YEAR)
                + SPAN_W'((nm_reg <= MONTH_BITS'(FEBRUARY)) ? cal_st.leap_cur
                                                            : cal_st.leap_next);
    assign dim  = month_len(nm_reg, cal_st.leap_cur);

    // Sequencer and datapath.
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        add_next       = add_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        leap1_next     = leap1_reg;
        leap2_next     = leap2_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        diff_next      = diff_reg;
        nd_next        = nd_reg;
        nm_next        = nm_reg;
        ovf_next       = ovf_reg;
        cal_ctl.load   = 1'b0;
        cal_ctl.step   = 1'b0;
        cal_ctl.year   = y1_reg;
        cal_ctl.r100   = r1_reg;
        cal_ctl.h4     = q1_reg[1:0];

        // The result register empties when taken.
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    y1_next    = req_y1;
                    y2_next    = clamp_year(req.second_year);
                    m1_next    = clamp_month(req.first_month);
                    m2_next    = clamp_month(req.second_month);
                    d1_next    = req.first_day;
                    d2_next    = req.second_day;
                    add_next   = req.add_days;
                    ovf_next   = 1'b0;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_st.done)
                begin
                    q1_next    = div_st.quot;
                    r1_next    = div_st.rem;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_st.done)
                begin
                    q2_next    = div_st.quot;
                    r2_next    = div_st.rem;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                d1_next      = clamp_day(d1_reg, lim1);
                d2_next      = clamp_day(d2_reg, lim2);
                leap1_next   = leap1;
                leap2_next   = leap2;
                nm_next      = m1_reg;
                cal_ctl.load = 1'b1;
                state_next   = ST_SER1;
            end
            ST_SER1:
            begin
                s1_next    = ser_val;
                nd_next    = ND_W'(d1_reg) + ND_W'(add_reg);
                state_next = ST_SER2;
            end
            ST_SER2:
            begin
                s2_next    = ser_val;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = (s1_reg >= s2_reg) ? s1_reg - s2_reg : s2_reg - s1_reg;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                // Skip whole years while more than twelve months remain.
                if (nd_reg <= ND_W'(span))
                    state_next = ST_MONTH;
                else if (cal_st.at_max)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    nd_next      = nd_reg - ND_W'(span);
                    cal_ctl.step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                // Walk the remaining months one at a time.
                if (nd_reg <= ND_W'(dim))
                    state_next = ST_DONE;
                else
                begin
                    nd_next = nd_reg - ND_W'(dim);
                    if (nm_reg == MONTH_BITS'(NUM_MONTHS))
                    begin
                        if (cal_st.at_max)
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            nm_next      = MONTH_BITS'(1);
                            cal_ctl.step = 1'b1;
                        end
                    end
                    else
                        nm_next = nm_reg + MONTH_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    res_valid_next         = 1'b1;
                    res_next.day_difference = DIFF_BITS'(diff_reg);
                    res_next.year_overflow = ovf_reg;
                    if (ovf_reg)
                    begin
                        res_next.sum_day   = DAY_BITS'(LAST_DAY);
                        res_next.sum_month = MONTH_BITS'(NUM_MONTHS);
                        res_next.sum_year  = YEAR_MAX;
                    end
                    else
                    begin
                        res_next.sum_day   = nd_reg[DAY_BITS-1:0];
                        res_next.sum_month = nm_reg;
                        res_next.sum_year  = cal_st.year;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        y1_reg    <= y1_next;
        y2_reg    <= y2_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        add_reg   <= add_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
        leap1_reg <= leap1_next;
        leap2_reg <= leap2_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        diff_reg  <= diff_next;
        nd_reg    <= nd_next;
        nm_reg    <= nm_next;
        ovf_reg   <= ovf_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An overflowed sum is always December 31 of the largest year.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.year_overflow) |->
            ((res_reg.sum_year == YEAR_MAX) &&
             (res_reg.sum_month == MONTH_BITS'(NUM_MONTHS)) &&
             (res_reg.sum_day == DAY_BITS'(LAST_DAY))))
        else $error("overflowed result not saturated");

    // The month walk keeps a real month.
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MONTH) || (state_reg == ST_YEAR)) |->
            ((nm_reg >= MONTH_BITS'(1)) && (nm_reg <= MONTH_BITS'(NUM_MONTHS))))
        else $error("walking month out of range");

    // A finished walk leaves a day that fits its month.
    a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !ovf_reg) |->
            ((nd_reg >= ND_W'(1)) && (nd_reg <= ND_W'(dim))))
        else $error("walked day does not fit its month");

    // A new result is only loaded when the output register is free or drains.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> !$past(res_load))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
